// File: sv/pixel_frame_store_with_fill_defines.svh
// assertion macros for the pixel frame store checker
`ifndef PIXEL_FRAME_STORE_WITH_FILL_DEFINES_SVH
`define PIXEL_FRAME_STORE_WITH_FILL_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types and constants of the pixel frame store: item kinds, queue
// entry layout and configuration register codes.
// ----------------------------------------------------------------------------
package pfs_pkg;

    // width of a linear pixel address before it is checked against the store
    localparam int ADDR_W = 16;

    // depth of the queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // configuration register indexes and reset values
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;
    localparam logic [7:0] COLS_RESET = 8'd21;
    localparam logic [7:0] ROWS_RESET = 8'd6;

    typedef enum logic [1:0] {
        KIND_DRAW = 2'd0,
        KIND_READ = 2'd1,
        KIND_FILL = 2'd2
    } kind_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef struct packed {
        logic [7:0] cols;
        logic [7:0] rows;
    } cfg_t;

    // one classified operation: a clipped rectangle walk or a single read
    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] start_addr;
        logic [7:0]        ext_w;
        logic [7:0]        ext_h;
        logic [31:0]       color;
    } q_entry_t;

endpackage

// File: sv/pfs_ram.sv
// ----------------------------------------------------------------------------
// pfs_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// File: sv/pfs_front.sv
// ----------------------------------------------------------------------------
// pfs_front
// Accepts items, clips them against the panel, turns them into queue entries
// and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module pfs_front import pfs_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        hold,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [7:0]  pos_x,
    input  logic [7:0]  pos_y,
    input  logic [7:0]  fill_width,
    input  logic [7:0]  fill_height,
    input  logic [31:0] color,
    output q_entry_t    head,
    output logic        head_valid,
    input  logic        head_pop
);

    q_entry_t          q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic        x_in, y_in;
    logic [7:0]  x_room, y_room;
    logic        keep;
    q_entry_t    entry;
    logic        push_acc, pop_acc;

    // clipping against the panel edges
    always_comb
    begin
        x_in   = pos_x < cfg.cols;
        y_in   = pos_y < cfg.rows;
        x_room = cfg.cols - pos_x;
        y_room = cfg.rows - pos_y;
        entry.color      = color;
        entry.start_addr = ADDR_W'({8'd0, pos_y} * {8'd0, cfg.cols}) + ADDR_W'(pos_x);
        entry.op    = OP_WRITE;
        entry.ext_w = 8'd0;
        entry.ext_h = 8'd0;
        keep        = 1'b0;
        case (kind)
            KIND_DRAW:
            begin
                entry.ext_w = 8'd1;
                entry.ext_h = 8'd1;
                keep        = x_in && y_in;
            end
            KIND_READ:
            begin
                entry.op    = OP_READ;
                entry.ext_w = (x_in && y_in) ? 8'd1 : 8'd0;
                entry.ext_h = (x_in && y_in) ? 8'd1 : 8'd0;
                keep        = 1'b1;
            end
            KIND_FILL:
            begin
                entry.ext_w = !x_in ? 8'd0 : ((fill_width < x_room) ? fill_width : x_room);
                entry.ext_h = !y_in ? 8'd0 : ((fill_height < y_room) ? fill_height : y_room);
                keep        = (entry.ext_w != 8'd0) && (entry.ext_h != 8'd0);
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // queue control
    always_comb
    begin
        full       = (count_reg == QCNT_W'(QDEPTH)) || hold;
        push_acc   = push && !full && keep;
        head_valid = count_reg != '0;
        pop_acc    = head_pop && head_valid;
        head       = q_mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_acc)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_acc)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_acc && !pop_acc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_acc && !push_acc)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push_acc)
        begin
            q_mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

// File: sv/pfs_back.sv
// ----------------------------------------------------------------------------
// pfs_back
// Carries out queued operations on the frame memory: clears it after reset,
// walks clipped rectangles one cell a cycle and serves reads into a result
// register.
// ----------------------------------------------------------------------------
module pfs_back import pfs_pkg::*; #(
    parameter int MAX_PIXELS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  stride,
    input  q_entry_t    head,
    input  logic        head_valid,
    output logic        head_pop,
    output logic        clearing,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] read_color
);

    localparam int AW = $clog2(MAX_PIXELS);
    localparam logic [ADDR_W-1:0] LIMIT = ADDR_W'(MAX_PIXELS);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_RDWAIT
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [ADDR_W-1:0] row_addr_reg, row_addr_next;
    logic [7:0]        col_reg, col_next;
    logic [7:0]        row_reg, row_next;
    logic [7:0]        ext_w_reg, ext_w_next;
    logic [7:0]        ext_h_reg, ext_h_next;
    logic [31:0]       color_reg, color_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_data_reg, out_data_next;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_addr;
    logic [31:0]       ram_wdata, ram_rdata;
    logic [ADDR_W-1:0] cell_addr;

    pfs_ram #(
        .WIDTH (32),
        .DEPTH (MAX_PIXELS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        row_addr_next  = row_addr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        ext_w_next     = ext_w_reg;
        ext_h_next     = ext_h_reg;
        color_next     = color_reg;
        out_valid_next = out_valid_reg && !pop;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_addr       = '0;
        ram_wdata      = color_reg;
        head_pop       = 1'b0;
        cell_addr      = row_addr_reg + ADDR_W'(col_reg);

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(MAX_PIXELS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    case (head.op)
                        OP_WRITE:
                        begin
                            head_pop      = 1'b1;
                            row_addr_next = head.start_addr;
                            col_next      = 8'd0;
                            row_next      = 8'd0;
                            ext_w_next    = head.ext_w;
                            ext_h_next    = head.ext_h;
                            color_next    = head.color;
                            state_next    = ST_WALK;
                        end
                        OP_READ:
                        begin
                            if (!out_valid_reg)
                            begin
                                head_pop = 1'b1;
                                if ((head.ext_w == 8'd0) || (head.start_addr >= LIMIT))
                                begin
                                    out_valid_next = 1'b1;
                                    out_data_next  = '0;
                                end
                                else
                                begin
                                    ram_re     = 1'b1;
                                    ram_addr   = head.start_addr[AW-1:0];
                                    state_next = ST_RDWAIT;
                                end
                            end
                        end
                        default:
                        begin
                            head_pop = 1'b0;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // cells past the end of the store are dropped
                if (cell_addr < LIMIT)
                begin
                    ram_we   = 1'b1;
                    ram_addr = cell_addr[AW-1:0];
                end
                if (col_reg == 8'(ext_w_reg - 8'd1))
                begin
                    col_next      = 8'd0;
                    row_next      = row_reg + 8'd1;
                    row_addr_next = row_addr_reg + ADDR_W'(stride);
                    if (row_reg == 8'(ext_h_reg - 8'd1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    col_next = col_reg + 8'd1;
                end
            end
            ST_RDWAIT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = ram_rdata;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            row_addr_reg  <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            ext_w_reg     <= '0;
            ext_h_reg     <= '0;
            color_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            row_addr_reg  <= row_addr_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            ext_w_reg     <= ext_w_next;
            ext_h_reg     <= ext_h_next;
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign clearing   = state_reg == ST_CLEAR;
    assign empty      = !out_valid_reg;
    assign read_color = out_data_reg;

endmodule

// File: sv/pixel_frame_store_with_fill.sv
// ----------------------------------------------------------------------------
// pixel_frame_store_with_fill
// Frame store for a small LED panel with pixel draw, pixel read and
// rectangle fill, configured through an APB-style register port.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the push/full queue side: kind, position, fill size and
//   colour. Draws and fills give no result; every read gives one result
//   transfer on the empty/pop side, in order. The user writes registers
//   panel_cols (0x0) and panel_rows (0x4) only while the block is idle;
//   the block does not enforce this. Items are accepted into a two-entry
//   queue; the back end takes one operation at a time. After its take, a
//   draw makes one cell write and a fill one frame memory write per cell of
//   the clipped rectangle; a read gives a zero result with no memory access
//   when the pixel lies outside, else goes through the memory's registered
//   read port. The result is registered onto read_color, and a read stalls
//   in the back end while the result register is still occupied; the queue
//   keeps accepting until it holds two entries, then full rises. After reset
//   the frame memory is cleared one word a cycle, all MAX_PIXELS words, with
//   full held high; register writes are taken throughout.
// ----------------------------------------------------------------------------
module pixel_frame_store_with_fill import pfs_pkg::*; #(
    parameter int MAX_PIXELS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [7:0]  pos_x,
    input  logic [7:0]  pos_y,
    input  logic [7:0]  fill_width,
    input  logic [7:0]  fill_height,
    input  logic [31:0] color,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] read_color
);

    cfg_t     cfg_reg, cfg_next;
    logic     cfg_we;
    logic     reg_sel;
    q_entry_t head;
    logic     head_valid, head_pop;
    logic     clearing;

    // configuration registers
    always_comb
    begin
        pready   = 1'b1;
        cfg_we   = psel && penable && pwrite && pready;
        reg_sel  = paddr[2];
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_sel)
                REG_COLS: cfg_next.cols = pwdata[7:0];
                REG_ROWS: cfg_next.rows = pwdata[7:0];
                default:  cfg_next = cfg_reg;
            endcase
        end
        case (reg_sel)
            REG_COLS: prdata = {24'd0, cfg_reg.cols};
            REG_ROWS: prdata = {24'd0, cfg_reg.rows};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cols <= COLS_RESET;
            cfg_reg.rows <= ROWS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: accept, clip and queue
    pfs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .hold        (clearing),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .fill_width  (fill_width),
        .fill_height (fill_height),
        .color       (color),
        .head        (head),
        .head_valid  (head_valid),
        .head_pop    (head_pop)
    );

    // back end: frame memory and result register
    pfs_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .stride     (cfg_reg.cols),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .clearing   (clearing),
        .empty      (empty),
        .pop        (pop),
        .read_color (read_color)
    );

endmodule

// File: sv/pfs_checker.sv
// ----------------------------------------------------------------------------
// pfs_checker
// Port-level checks on the pixel frame store: result ordering against read
// transfers, result hold under stall and the clearing pass after reset.
// ----------------------------------------------------------------------------
`include "pixel_frame_store_with_fill_defines.svh"

module pfs_checker import pfs_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic [1:0]  kind,
    input logic        empty,
    input logic        pop,
    input logic [31:0] read_color
);

    logic [2:0] pend_reg;
    logic       rd_in, rd_out;

    // reads accepted whose results are not yet taken
    assign rd_in  = push && !full && (kind == KIND_READ);
    assign rd_out = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (rd_in && !rd_out)
        begin
            pend_reg <= pend_reg + 3'd1;
        end
        else if (rd_out && !rd_in)
        begin
            pend_reg <= pend_reg - 3'd1;
        end
    end

    // a result only stands for an accepted read
    `PFS_ASSERT_IMP(a_no_spurious, !empty, pend_reg != 3'd0, "result without a read")

    // queue plus result register bound the reads in flight
    `PFS_ASSERT_IMP(a_pend_bound, 1'b1, pend_reg <= 3'd3, "too many reads in flight")

    // a stalled result holds
    `PFS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(read_color), "result lost")

    // memory clearing pass follows reset
    `PFS_ASSERT_IMP(a_clear, $rose(rst_n), full, "item accepted during clearing")

endmodule

bind pixel_frame_store_with_fill pfs_checker u_pfs_checker (.*);
